### sv/rwl_pkg.sv
// ----------------------------------------------------------------------------
// rwl_pkg
// shared types and constants of the reader-writer lock arbiter
// ----------------------------------------------------------------------------
`default_nettype none

package rwl_pkg;

    // request codes
    typedef enum logic [1:0] {
        FN_ENTER_RD = 2'd0,
        FN_ENTER_WR = 2'd1,
        FN_EXIT_RD  = 2'd2,
        FN_EXIT_WR  = 2'd3
    } func_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP_W,
        ST_RUN
    } state_t;

    // result status codes
    localparam logic STATUS_GRANTED = 1'b0;
    localparam logic STATUS_REFUSED = 1'b1;

    // reader count is a saturating 9-bit counter
    localparam int READERS_W = 9;
    localparam logic [READERS_W-1:0] READERS_MAX = 9'd511;

endpackage

`default_nettype wire

### sv/reader_writer_lock_arbiter_core.sv
// ----------------------------------------------------------------------------
// reader_writer_lock_arbiter_core
// fifo reader-writer lock manager with ram-backed reader and writer wait queues
// ----------------------------------------------------------------------------
//  channel   handshake                    word
//  request   start / busy                 func, thread_id
//  result    result_strobe (no stall)     grant_thread, grant_is_writer, status, last
//
//  an immediate grant or a refusal needs no queue ram read; its result word
//  shows in the cycle after the request is taken; a queued request shows none
//  a writer grant popped from its wait queue costs one queue ram read: the
//  word passes the ram read and result registers, busy high for one cycle
//  an exit write that releases n waiting readers emits one word per cycle
//  from the reader queue ram, busy high until the run of n words ends
//  reset clears pointers, fill counts and lock state; queue ram is not cleared
//  the receiver cannot stall: each result word is valid for exactly one cycle
// ----------------------------------------------------------------------------
`default_nettype none

module reader_writer_lock_arbiter_core
    import rwl_pkg::*;
#(
    parameter int QUEUE_DEPTH    = 16,
    parameter int THREAD_ID_BITS = 8
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output      logic                      busy,
    input  wire logic [1:0]                func,
    input  wire logic [THREAD_ID_BITS-1:0] thread_id,
    output      logic                      result_strobe,
    output      logic [THREAD_ID_BITS-1:0] grant_thread,
    output      logic                      grant_is_writer,
    output      logic                      status,
    output      logic                      last
);

    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    state_t state_reg, state_next;

    // lock state
    logic [READERS_W-1:0] readers_reg, readers_next;
    logic                 wact_reg, wact_next;

    // result word registers
    logic                      strobe_reg, strobe_next;
    logic [THREAD_ID_BITS-1:0] thread_reg, thread_next;
    logic                      is_wr_reg, is_wr_next;
    logic                      status_reg, status_next;
    logic                      last_reg, last_next;

    // queue controls
    logic                      push_r, push_w, pop_r, pop_w;
    logic [THREAD_ID_BITS-1:0] r_data, w_data;
    logic [FILL_W-1:0]         r_fill, w_fill;

    logic  accept;
    func_t fn;
    logic  r_full, w_full;

    assign accept = start && (state_reg == ST_IDLE);
    assign fn     = func_t'(func);
    assign r_full = (r_fill == FILL_W'(QUEUE_DEPTH));
    assign w_full = (w_fill == FILL_W'(QUEUE_DEPTH));

    rwl_queue #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (THREAD_ID_BITS)
    ) u_rd_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push_r),
        .push_data (thread_id),
        .pop       (pop_r),
        .pop_data  (r_data),
        .fill      (r_fill)
    );

    rwl_queue #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (THREAD_ID_BITS)
    ) u_wr_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push_w),
        .push_data (thread_id),
        .pop       (pop_w),
        .pop_data  (w_data),
        .fill      (w_fill)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (fn)
                        FN_EXIT_RD:
                        begin
                            // last reader out hands the lock to the oldest writer
                            if (readers_reg == READERS_W'(1) && w_fill != '0)
                            begin
                                state_next = ST_POP_W;
                            end
                        end
                        FN_EXIT_WR:
                        begin
                            if (wact_reg)
                            begin
                                if (r_fill != '0)
                                begin
                                    state_next = ST_RUN;
                                end
                                else if (w_fill != '0)
                                begin
                                    state_next = ST_POP_W;
                                end
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_POP_W:
            begin
                state_next = ST_IDLE;
            end
            ST_RUN:
            begin
                // reader fill already counts the pops issued so far
                if (r_fill == '0)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // lock state, queue controls and result word
    always_comb
    begin
        readers_next = readers_reg;
        wact_next    = wact_reg;
        strobe_next  = 1'b0;
        thread_next  = thread_reg;
        is_wr_next   = is_wr_reg;
        status_next  = status_reg;
        last_next    = last_reg;
        push_r       = 1'b0;
        push_w       = 1'b0;
        pop_r        = 1'b0;
        pop_w        = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (fn)
                        FN_ENTER_RD:
                        begin
                            if (!wact_reg && w_fill == '0)
                            begin
                                if (readers_reg != READERS_MAX)
                                begin
                                    readers_next = readers_reg + 1'b1;
                                end
                                strobe_next = 1'b1;
                                thread_next = thread_id;
                                is_wr_next  = 1'b0;
                                status_next = STATUS_GRANTED;
                                last_next   = 1'b1;
                            end
                            else if (r_full)
                            begin
                                strobe_next = 1'b1;
                                thread_next = thread_id;
                                is_wr_next  = 1'b0;
                                status_next = STATUS_REFUSED;
                                last_next   = 1'b1;
                            end
                            else
                            begin
                                push_r = 1'b1;
                            end
                        end
                        FN_ENTER_WR:
                        begin
                            if (readers_reg == '0 && !wact_reg)
                            begin
                                wact_next   = 1'b1;
                                strobe_next = 1'b1;
                                thread_next = thread_id;
                                is_wr_next  = 1'b1;
                                status_next = STATUS_GRANTED;
                                last_next   = 1'b1;
                            end
                            else if (w_full)
                            begin
                                strobe_next = 1'b1;
                                thread_next = thread_id;
                                is_wr_next  = 1'b1;
                                status_next = STATUS_REFUSED;
                                last_next   = 1'b1;
                            end
                            else
                            begin
                                push_w = 1'b1;
                            end
                        end
                        FN_EXIT_RD:
                        begin
                            // exit read with no readers is dropped
                            if (readers_reg != '0)
                            begin
                                readers_next = readers_reg - 1'b1;
                                if (readers_reg == READERS_W'(1) && w_fill != '0)
                                begin
                                    pop_w     = 1'b1;
                                    wact_next = 1'b1;
                                end
                            end
                        end
                        FN_EXIT_WR:
                        begin
                            if (wact_reg)
                            begin
                                wact_next = 1'b0;
                                if (r_fill != '0)
                                begin
                                    pop_r = 1'b1;
                                end
                                else if (w_fill != '0)
                                begin
                                    pop_w     = 1'b1;
                                    wact_next = 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                            push_r = 1'b0;
                        end
                    endcase
                end
            end
            ST_POP_W:
            begin
                // writer id read from ram last cycle
                strobe_next = 1'b1;
                thread_next = w_data;
                is_wr_next  = 1'b1;
                status_next = STATUS_GRANTED;
                last_next   = 1'b1;
            end
            ST_RUN:
            begin
                // one waiting reader granted per cycle, next read issued alongside
                strobe_next = 1'b1;
                thread_next = r_data;
                is_wr_next  = 1'b0;
                status_next = STATUS_GRANTED;
                last_next   = (r_fill == '0);
                if (readers_reg != READERS_MAX)
                begin
                    readers_next = readers_reg + 1'b1;
                end
                if (r_fill != '0)
                begin
                    pop_r = 1'b1;
                end
            end
            default:
            begin
                strobe_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            readers_reg <= '0;
            wact_reg    <= 1'b0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            readers_reg <= readers_next;
            wact_reg    <= wact_next;
            strobe_reg  <= strobe_next;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        thread_reg <= thread_next;
        is_wr_reg  <= is_wr_next;
        status_reg <= status_next;
        last_reg   <= last_next;
    end

    assign busy            = (state_reg != ST_IDLE);
    assign result_strobe   = strobe_reg;
    assign grant_thread    = thread_reg;
    assign grant_is_writer = is_wr_reg;
    assign status          = status_reg;
    assign last            = last_reg;

    // a writer never shares the lock with readers
    a_exclusive : assert property (@(posedge clk) disable iff (!rst_n)
        !(wact_reg && readers_reg != '0))
        else $error("writer active while readers hold the lock");

    // a writer grant is shown only while the writer holds the lock
    a_wr_grant_held : assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && is_wr_reg && status_reg == STATUS_GRANTED) |-> wact_reg)
        else $error("writer grant without active writer");

    // a queued writer pop yields exactly one final word
    a_pop_w_word : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POP_W) |=> (strobe_reg && last_reg && is_wr_reg))
        else $error("writer pop without final grant word");

    // every cycle of a reader run emits a reader grant
    a_run_word : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |=> (strobe_reg && !is_wr_reg))
        else $error("reader run cycle without grant word");

endmodule

`default_nettype wire

### sv/rwl_ram.sv
// ----------------------------------------------------------------------------
// rwl_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module rwl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### sv/rwl_queue.sv
// ----------------------------------------------------------------------------
// rwl_queue
// wait queue: head, tail and fill count around one ram
// ----------------------------------------------------------------------------
`default_nettype none

module rwl_queue #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       push,
    input  wire logic [WIDTH-1:0]           push_data,
    input  wire logic                       pop,
    output      logic [WIDTH-1:0]           pop_data,
    output      logic [$clog2(DEPTH+1)-1:0] fill
);

    localparam int PTR_W  = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH + 1);

    logic [PTR_W-1:0]  head_reg, head_next;
    logic [PTR_W-1:0]  tail_reg, tail_next;
    logic [FILL_W-1:0] fill_reg, fill_next;

    // pointer advance with wrap for any depth
    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        fill_next = fill_reg;
        if (pop)
        begin
            head_next = (head_reg == PTR_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
        end
        if (push)
        begin
            tail_next = (tail_reg == PTR_W'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            fill_reg <= fill_next;
        end
    end

    // pop reads the head entry; the word shows in the next cycle
    rwl_ram #(
        .WIDTH (WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (push),
        .waddr (tail_reg),
        .wdata (push_data),
        .re    (pop),
        .raddr (head_reg),
        .rdata (pop_data)
    );

    assign fill = fill_reg;

    a_no_underflow : assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (fill_reg != '0))
        else $error("pop from empty queue");

    a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (fill_reg != FILL_W'(DEPTH)))
        else $error("push into full queue");

endmodule

`default_nettype wire
